FILE: src/paged_kv_slot_mapper_top_assert.svh
// Assertion macros for the slot mapper.
`ifndef PAGED_KV_SLOT_MAPPER_TOP_ASSERT_SVH
`define PAGED_KV_SLOT_MAPPER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PKVSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PKVSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pkvsm_pkg.sv
`timescale 1ns / 1ps

package pkvsm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int PHYS_BLOCKS = 4096;

  localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int BS_W    = 7;
  localparam int LIMIT_W = 9;
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 13;
  localparam int START_W = 16;
  localparam int OFS_W   = 10;
  localparam int POS_W   = 17;
  localparam int SLOT_W  = 19;
  localparam int ST_W    = 2;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 9;

  localparam logic [SLOT_W-1:0] SLOT_NONE = '1;
  localparam logic [SLOT_W:0]   SLOT_MAX  = 20'd262143;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_CAPACITY = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_BLK_LEN     = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_TABLE_LIMIT = 2'd1;

  localparam logic [BS_W-1:0]    BS_RESET    = 7'd16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_MAP   = 1'b1;

endpackage

FILE: src/paged_kv_slot_mapper_top.sv
`timescale 1ns / 1ps
// A table write goes from acceptance straight to the result load; a map
// transaction runs 17 restoring divide steps, then table read, multiply, add and
// result load, and skips to the result load on a lookup error or a zero block length.
// One transaction in flight at a time: the next is accepted only once the result
// is loaded; a stalled output holds the finished result in the done state.
// Reset: block length 16, table_limit 256, every table entry empty (valid bits clear).

module paged_kv_slot_mapper_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [pkvsm_pkg::IDX_W-1:0]         entry_index_i,
  input  logic signed [pkvsm_pkg::VAL_W-1:0]  entry_value_i,
  input  logic [pkvsm_pkg::START_W-1:0]       batch_base_i,
  input  logic [pkvsm_pkg::OFS_W-1:0]         token_offset_i,
  input  logic                                last_token_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pkvsm_pkg::SLOT_W-1:0] slot_o,
  output logic [pkvsm_pkg::ST_W-1:0]          status_o,
  output logic                                last_result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pkvsm_pkg::CFG_AW-1:0]        cfg_index_i,
  input  logic [pkvsm_pkg::CFG_DW-1:0]        cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int CNT_W = $clog2(pkvsm_pkg::POS_W + 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(pkvsm_pkg::POS_W - 1);
  localparam logic [pkvsm_pkg::POS_W-1:0] DEPTH_POS = pkvsm_pkg::POS_W'(pkvsm_pkg::TABLE_DEPTH);
  localparam logic [pkvsm_pkg::IDX_W+4:0] DEPTH_IDX =
    (pkvsm_pkg::IDX_W + 5)'(pkvsm_pkg::TABLE_DEPTH);
  localparam logic [20:0] PHYS_LIM = 21'(pkvsm_pkg::PHYS_BLOCKS);

  logic [2:0] state_q, state_d;
  logic [pkvsm_pkg::BS_W-1:0]    blk_len_q;
  logic [pkvsm_pkg::LIMIT_W-1:0] table_limit_q;

  logic [pkvsm_pkg::POS_W-1:0] pos_q;
  logic [pkvsm_pkg::BS_W:0]    rem_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        last_q;

  logic [pkvsm_pkg::SLOT_W-1:0] res_slot_q;
  logic [pkvsm_pkg::ST_W-1:0]   res_status_q;
  logic                         res_last_q;

  logic [pkvsm_pkg::VAL_W-1:0]  mem_q [pkvsm_pkg::TABLE_DEPTH];
  logic [pkvsm_pkg::TABLE_DEPTH-1:0] valid_q;
  logic [pkvsm_pkg::VAL_W-1:0]  rd_data_q;
  logic                         rd_vld_q;
  logic [pkvsm_pkg::SLOT_W-1:0] prod_q;

  logic                         out_valid_q;
  logic [pkvsm_pkg::SLOT_W-1:0] out_slot_q;
  logic [pkvsm_pkg::ST_W-1:0]   out_status_q;
  logic                         out_last_q;

  logic                         in_accept;
  logic                         wr_en;
  logic                         rd_en;
  logic [pkvsm_pkg::TBL_AW-1:0] wr_addr;
  logic [pkvsm_pkg::TBL_AW-1:0] rd_addr;
  logic [pkvsm_pkg::BS_W:0]     shifted;
  logic [pkvsm_pkg::BS_W:0]     divisor;
  logic                         div_ge;
  logic                         out_cap;
  logic [pkvsm_pkg::VAL_W-1:0]  phys;
  logic                         phys_big;
  logic [pkvsm_pkg::SLOT_W:0]   sum;
  logic                         res_load;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  assign wr_en   = in_accept && (opcode_i == pkvsm_pkg::OP_WRITE) &&
                   ({5'd0, entry_index_i} < DEPTH_IDX);
  assign wr_addr = pkvsm_pkg::TBL_AW'(entry_index_i);

  assign out_cap = ({8'd0, table_limit_q} <= pos_q) || (pos_q >= DEPTH_POS);
  assign rd_en   = (state_q == S_LOOK) && !out_cap;
  assign rd_addr = pkvsm_pkg::TBL_AW'(pos_q);

  assign divisor = {1'b0, blk_len_q};
  assign shifted = {rem_q[pkvsm_pkg::BS_W-1:0], pos_q[pkvsm_pkg::POS_W-1]};
  assign div_ge  = (shifted >= divisor);

  assign phys     = rd_vld_q ? rd_data_q : '1;
  assign phys_big = ({9'd0, phys[pkvsm_pkg::VAL_W-2:0]} >= PHYS_LIM);
  assign sum      = {1'b0, prod_q} + {13'd0, rem_q[pkvsm_pkg::BS_W-1:0]};

  assign res_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (opcode_i == pkvsm_pkg::OP_WRITE || blk_len_q == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = out_cap ? S_DONE : S_MUL;
      end
      S_MUL: begin
        state_d = (phys[pkvsm_pkg::VAL_W-1] || phys_big) ? S_DONE : S_ADD;
      end
      S_ADD: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      blk_len_q     <= pkvsm_pkg::BS_RESET;
      table_limit_q <= pkvsm_pkg::LIMIT_RESET;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pkvsm_pkg::CFG_BLK_LEN:     blk_len_q     <= cfg_data_i[pkvsm_pkg::BS_W-1:0];
          pkvsm_pkg::CFG_TABLE_LIMIT: table_limit_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= entry_value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        pos_q  <= {1'b0, batch_base_i} + {7'd0, token_offset_i};
        rem_q  <= '0;
        cnt_q  <= '0;
        last_q <= last_token_i;
        res_slot_q <= pkvsm_pkg::SLOT_NONE;
        if (opcode_i == pkvsm_pkg::OP_WRITE) begin
          res_status_q <= pkvsm_pkg::ST_OK;
          res_last_q   <= 1'b0;
        end else begin
          res_status_q <= pkvsm_pkg::ST_CAPACITY;
          res_last_q   <= last_token_i;
        end
      end
      S_DIV: begin
        rem_q <= div_ge ? (shifted - divisor) : shifted;
        pos_q <= {pos_q[pkvsm_pkg::POS_W-2:0], div_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      S_LOOK: begin
        res_status_q <= pkvsm_pkg::ST_CAPACITY;
        res_last_q   <= last_q;
      end
      S_MUL: begin
        prod_q <= pkvsm_pkg::SLOT_W'(phys[pkvsm_pkg::VAL_W-2:0]) *
                  pkvsm_pkg::SLOT_W'(blk_len_q);
        if (phys[pkvsm_pkg::VAL_W-1]) begin
          res_status_q <= pkvsm_pkg::ST_EMPTY;
        end else begin
          res_status_q <= pkvsm_pkg::ST_CAPACITY;
        end
      end
      S_ADD: begin
        if (sum <= pkvsm_pkg::SLOT_MAX) begin
          res_slot_q   <= sum[pkvsm_pkg::SLOT_W-1:0];
          res_status_q <= pkvsm_pkg::ST_OK;
        end else begin
          res_status_q <= pkvsm_pkg::ST_CAPACITY;
        end
      end
      default: begin
      end
    endcase
    if (res_load) begin
      out_slot_q   <= res_slot_q;
      out_status_q <= res_status_q;
      out_last_q   <= res_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign slot_o        = $signed(out_slot_q);
  assign status_o      = out_status_q;
  assign last_result_o = out_last_q;

`include "paged_kv_slot_mapper_top_assert.svh"

  `PKVSM_ASSERT_NEXT(a_accept_busy, in_accept, in_stall_o, "accept did not raise stall")
  `PKVSM_ASSERT_NOW(a_err_slot, out_valid_o && (status_o != pkvsm_pkg::ST_OK), slot_o == -19'sd1, "error result with slot not -1")
  `PKVSM_ASSERT_NOW(a_load_done, $rose(out_valid_o), $past(state_q) == S_DONE, "result loaded outside done state")

endmodule

FILE: verif/paged_kv_slot_mapper_top_tb.sv
`timescale 1ns / 1ps

module paged_kv_slot_mapper_top_tb;

  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [pkvsm_pkg::CFG_AW-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [pkvsm_pkg::CFG_AW-1:0] CFG_UNUSED_3 = 2'd3;

  typedef struct {
    logic                               opcode;
    logic [pkvsm_pkg::IDX_W-1:0]        entry_index;
    logic signed [pkvsm_pkg::VAL_W-1:0] entry_value;
    logic [pkvsm_pkg::START_W-1:0]      batch_base;
    logic [pkvsm_pkg::OFS_W-1:0]        token_offset;
    logic                               last_token;
  } map_req_t;

  typedef struct {
    logic signed [pkvsm_pkg::SLOT_W-1:0] slot;
    logic [pkvsm_pkg::ST_W-1:0]          status;
    logic                                last_result;
  } slot_resp_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic                                opcode_i = 1'b0;
  logic [pkvsm_pkg::IDX_W-1:0]         entry_index_i = '0;
  logic signed [pkvsm_pkg::VAL_W-1:0]  entry_value_i = '0;
  logic [pkvsm_pkg::START_W-1:0]       batch_base_i = '0;
  logic [pkvsm_pkg::OFS_W-1:0]         token_offset_i = '0;
  logic                                last_token_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [pkvsm_pkg::SLOT_W-1:0] slot_o;
  logic [pkvsm_pkg::ST_W-1:0]          status_o;
  logic                                last_result_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [pkvsm_pkg::CFG_AW-1:0]        cfg_index_i = '0;
  logic [pkvsm_pkg::CFG_DW-1:0]        cfg_data_i = '0;

  paged_kv_slot_mapper_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .batch_base_i   (batch_base_i),
    .token_offset_i (token_offset_i),
    .last_token_i   (last_token_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .slot_o         (slot_o),
    .status_o       (status_o),
    .last_result_o  (last_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [pkvsm_pkg::VAL_W-1:0] phys_of_block [pkvsm_pkg::TABLE_DEPTH];
  logic [pkvsm_pkg::BS_W-1:0]         tokens_per_block = pkvsm_pkg::BS_RESET;
  logic [pkvsm_pkg::LIMIT_W-1:0]      usable_blocks = pkvsm_pkg::LIMIT_RESET;

  map_req_t   req_backlog[$];
  slot_resp_t slot_expect[$];
  slot_resp_t want;
  int         mismatch_cnt = 0;
  int         in_gap = 0;
  int         in_calm = 0;
  int         out_hold = 0;
  int         out_calm = 0;
  int         idle_cycles = 0;

  initial begin
    for (int i = 0; i < pkvsm_pkg::TABLE_DEPTH; i++) begin
      phys_of_block[pkvsm_pkg::TBL_AW'(i)] = '1;
    end
  end

  function automatic slot_resp_t predict_slot(input map_req_t r);
    slot_resp_t  o;
    logic [pkvsm_pkg::POS_W-1:0] pos;
    int unsigned lblk;
    int unsigned rem;
    int          phys;
    longint      s;
    o.slot = pkvsm_pkg::SLOT_NONE;
    o.status = pkvsm_pkg::ST_OK;
    o.last_result = 1'b0;
    if (r.opcode == pkvsm_pkg::OP_WRITE) begin
      if (int'(r.entry_index) < pkvsm_pkg::TABLE_DEPTH) begin
        phys_of_block[r.entry_index] = r.entry_value;
      end
      return o;
    end
    o.last_result = r.last_token;
    o.status = pkvsm_pkg::ST_CAPACITY;
    if (tokens_per_block == 0) return o;
    pos = {1'b0, r.batch_base} + {7'd0, r.token_offset};
    lblk = 32'(pos) / 32'(tokens_per_block);
    rem = 32'(pos) % 32'(tokens_per_block);
    if (lblk >= usable_blocks || lblk >= pkvsm_pkg::TABLE_DEPTH) return o;
    phys = int'(phys_of_block[lblk[pkvsm_pkg::TBL_AW-1:0]]);
    if (phys < 0) begin
      o.status = pkvsm_pkg::ST_EMPTY;
      return o;
    end
    if (phys >= pkvsm_pkg::PHYS_BLOCKS) return o;
    s = longint'(phys) * longint'(tokens_per_block) + longint'(rem);
    if (s > longint'(pkvsm_pkg::SLOT_MAX)) return o;
    o.slot = s[pkvsm_pkg::SLOT_W-1:0];
    o.status = pkvsm_pkg::ST_OK;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
      in_calm = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        slot_expect.push_back(predict_slot(req_backlog.pop_front()));
        if (in_calm > 0) begin
          in_calm--;
          in_gap = 0;
        end else begin
          in_gap = $urandom_range(0, 17);
          if ($urandom_range(0, 24) == 0) in_calm = $urandom_range(10, 40);
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          opcode_i       <= req_backlog[0].opcode;
          entry_index_i  <= req_backlog[0].entry_index;
          entry_value_i  <= req_backlog[0].entry_value;
          batch_base_i   <= req_backlog[0].batch_base;
          token_offset_i <= req_backlog[0].token_offset;
          last_token_i   <= req_backlog[0].last_token;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold = 0;
      out_calm = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (slot_expect.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with no transaction pending: slot %0d status %0d last %0b",
                   $time, slot_o, status_o, last_result_o);
        end else begin
          want = slot_expect.pop_front();
          if (slot_o !== want.slot) begin
            mismatch_cnt++;
            $display("%0t: slot expected %0d, got %0d", $time, want.slot, slot_o);
          end
          if (status_o !== want.status) begin
            mismatch_cnt++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          end
          if (last_result_o !== want.last_result) begin
            mismatch_cnt++;
            $display("%0t: last_result expected %0b, got %0b", $time, want.last_result,
                     last_result_o);
          end
        end
        if (out_calm > 0) begin
          out_calm--;
          out_hold = 0;
        end else begin
          out_hold = $urandom_range(0, 17);
          if ($urandom_range(0, 24) == 0) out_calm = $urandom_range(10, 40);
        end
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold > 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("paged_kv_slot_mapper_top_tb: errors");
        $finish;
      end
    end
  end

  task automatic queue_req(input logic op, input int idx, input int val, input int start,
                           input int ofs, input logic last);
    map_req_t r;
    r.opcode = op;
    r.entry_index = pkvsm_pkg::IDX_W'(idx);
    r.entry_value = pkvsm_pkg::VAL_W'(val);
    r.batch_base = pkvsm_pkg::START_W'(start);
    r.token_offset = pkvsm_pkg::OFS_W'(ofs);
    r.last_token = last;
    req_backlog.push_back(r);
  endtask

  task automatic program_reg(input logic [pkvsm_pkg::CFG_AW-1:0] idx,
                             input logic [pkvsm_pkg::CFG_DW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == pkvsm_pkg::CFG_BLK_LEN) tokens_per_block = data[pkvsm_pkg::BS_W-1:0];
    else if (idx == pkvsm_pkg::CFG_TABLE_LIMIT) usable_blocks = data[pkvsm_pkg::LIMIT_W-1:0];
  endtask

  task automatic drain();
    do @(posedge clk_i); while (req_backlog.size() != 0 || slot_expect.size() != 0);
  endtask

  task automatic queue_traffic(input int n_items);
    int made;
    int pick;
    int span;
    int n;
    int base;
    int ofs0;
    int idx_top;
    int val;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 9);
      idx_top = (usable_blocks == 0 || usable_blocks > pkvsm_pkg::TABLE_DEPTH) ?
                pkvsm_pkg::TABLE_DEPTH - 1 : int'(usable_blocks) - 1;
      span = int'(tokens_per_block) * (idx_top + 1);
      if (span == 0 || span > 65536) span = 65536;
      if (pick < 2) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(0, 9))
            8: val = -1;
            9: val = $urandom_range(0, 4095) - 4096;
            default: val = $urandom_range(0, 4095);
          endcase
          queue_req(pkvsm_pkg::OP_WRITE,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, idx_top),
                    val, $urandom_range(0, 65535), $urandom_range(0, 1023),
                    1'($urandom_range(0, 1)));
        end
        made += n;
      end else if (pick < 9) begin
        n = $urandom_range(1, 16);
        base = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, span - 1);
        ofs0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1024 - n) : 0;
        for (int k = 0; k < n; k++) begin
          queue_req(pkvsm_pkg::OP_MAP, $urandom_range(0, 255), $urandom_range(0, 8191) - 4096,
                    base, ofs0 + k, k == n - 1);
        end
        made += n;
      end else begin
        queue_req(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                  $urandom_range(0, 8191) - 4096, $urandom_range(0, 65535),
                  $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  initial begin
    int bs_plan[7];
    int lim_plan[7];
    bs_plan = '{1, 64, 127, 0, 8, 65, 416};
    lim_plan = '{1, 256, 511, 100, 0, 300, 256};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_req(pkvsm_pkg::OP_MAP, 0, 0, 0, 0, 1'b1);
    queue_req(pkvsm_pkg::OP_WRITE, 0, 0, 0, 0, 1'b0);
    queue_req(pkvsm_pkg::OP_WRITE, 255, 4095, 65535, 1023, 1'b1);
    queue_req(pkvsm_pkg::OP_WRITE, 1, -1, 0, 0, 1'b0);
    queue_req(pkvsm_pkg::OP_WRITE, 2, -4096, 0, 0, 1'b0);
    queue_req(pkvsm_pkg::OP_WRITE, 3, 7, 0, 0, 1'b0);
    queue_req(pkvsm_pkg::OP_MAP, 255, -4096, 0, 0, 1'b1);
    queue_req(pkvsm_pkg::OP_MAP, 0, 0, 4080, 15, 1'b0);
    queue_req(pkvsm_pkg::OP_MAP, 0, 0, 16, 0, 1'b0);
    queue_req(pkvsm_pkg::OP_MAP, 0, 0, 32, 3, 1'b0);
    queue_req(pkvsm_pkg::OP_MAP, 0, 0, 48, 5, 1'b1);
    queue_req(pkvsm_pkg::OP_MAP, 0, 0, 65535, 1023, 1'b1);
    queue_req(pkvsm_pkg::OP_MAP, 0, 0, 4095, 1, 1'b0);
    queue_req(pkvsm_pkg::OP_MAP, 0, 0, 3072, 1023, 1'b1);
    drain();

    for (int p = 0; p < 7; p++) begin
      program_reg(pkvsm_pkg::CFG_BLK_LEN, pkvsm_pkg::CFG_DW'(bs_plan[p]));
      program_reg(pkvsm_pkg::CFG_TABLE_LIMIT, pkvsm_pkg::CFG_DW'(lim_plan[p]));
      cfg_valid_i <= 1'b0;
      if (p == 1) queue_req(pkvsm_pkg::OP_MAP, 0, 0, 255 * 64 + 63, 0, 1'b1);
      queue_traffic(100);
      drain();
    end

    for (int p = 0; p < 6; p++) begin
      program_reg(pkvsm_pkg::CFG_BLK_LEN, pkvsm_pkg::CFG_DW'($urandom_range(1, 64)));
      program_reg(pkvsm_pkg::CFG_TABLE_LIMIT, pkvsm_pkg::CFG_DW'($urandom_range(1, 256)));
      if (p == 2) begin
        program_reg(CFG_UNUSED_2, pkvsm_pkg::CFG_DW'($urandom_range(0, 511)));
        program_reg(CFG_UNUSED_3, 9'h1FF);
      end
      cfg_valid_i <= 1'b0;
      queue_traffic(125);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && slot_expect.size() == 0) begin
      $display("paged_kv_slot_mapper_top_tb: clean");
    end else begin
      $display("paged_kv_slot_mapper_top_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/pkvsm_pkg.sv
src/paged_kv_slot_mapper_top.sv
verif/paged_kv_slot_mapper_top_tb.sv
